### rtl/least_loaded_task_dispatcher_defines.svh
// Assertion macros used by the dispatcher controller.
`ifndef LEAST_LOADED_TASK_DISPATCHER_DEFINES_SVH
`define LEAST_LOADED_TASK_DISPATCHER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LLTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LLTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lltd_pkg.sv
// Shared constants, types and the weight table of the dispatcher.
`timescale 1ns / 1ps
package lltd_pkg;

  // Default sizing handed to the top level parameters
  localparam int unsigned DEF_MAX_WORKERS = 16;
  localparam int unsigned DEF_COUNT_WIDTH = 16;

  // Item kinds
  localparam logic [1:0] KIND_LEAST  = 2'd0;
  localparam logic [1:0] KIND_IDLE   = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  // Phase code that limits the weight
  localparam logic [1:0] PHASE_FINAL = 2'd2;

  // Register map: index of the worker count register
  localparam logic REG_NUM_WORKERS = 1'b0;
  localparam logic [4:0] NUM_WORKERS_RST = 5'd16;

  // Weight limits and reset value
  localparam logic [3:0] WEIGHT_CAP = 4'd10;
  localparam logic [3:0] FINAL_CAP  = 4'd2;
  localparam logic [3:0] WEIGHT_RST = 4'd1;

  // Width of outstanding+1 for the widest counter
  localparam int unsigned XW = 33;
  localparam int unsigned NUM_THR = 9;

  // ceil(e^k) for k = 1..9
  localparam logic [XW-1:0] WEIGHT_THR [NUM_THR] = '{
    33'd3, 33'd8, 33'd21, 33'd55, 33'd149, 33'd404, 33'd1097, 33'd2981, 33'd8104
  };

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_sel_item;
    logic cmp_en;
    logic cmp_first;
    logic mark_wr;
    logic upd_wr;
    logic commit;
    logic res_zero;
    logic out_load;
  } lltd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_update;
    logic is_idle_req;
    logic out_free;
  } lltd_sts_t;

  // floor(ln(x))+1 through the threshold table, with the phase cap
  function automatic logic [3:0] weight_of(input logic [XW-1:0] x, input logic final_phase);
    logic [3:0] w;
    w = WEIGHT_RST;
    for (int k = 0; k < NUM_THR; k++) begin
      if (x >= WEIGHT_THR[k]) begin
        w = w + 4'd1;
      end
    end
    if (final_phase && (w > FINAL_CAP)) begin
      w = FINAL_CAP;
    end
    if (w > WEIGHT_CAP) begin
      w = WEIGHT_CAP;
    end
    return w;
  endfunction

endpackage

### rtl/lltd_intf.sv
// Request and result channel interfaces of the dispatcher.
`timescale 1ns / 1ps
interface lltd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  worker_id;
  logic [15:0] done_count;
  logic [1:0]  phase;

  modport source (output valid, output kind, output worker_id, output done_count,
                  output phase, input ready);
  modport sink   (input valid, input kind, input worker_id, input done_count,
                  input phase, output ready);
endinterface

interface lltd_res_if;
  logic       valid;
  logic       ready;
  logic       dispatched;
  logic [3:0] chosen_worker;
  logic [3:0] task_weight;

  modport source (output valid, output dispatched, output chosen_worker,
                  output task_weight, input ready);
  modport sink   (input valid, input dispatched, input chosen_worker,
                  input task_weight, output ready);
endinterface

### rtl/lltd_ctrl.sv
// Sequencer of the dispatcher: decode, slot scan, commit and result handoff.
`timescale 1ns / 1ps
`include "least_loaded_task_dispatcher_defines.svh"
module lltd_ctrl #(
  parameter int unsigned MAX_WORKERS = lltd_pkg::DEF_MAX_WORKERS,
  localparam int unsigned IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [IDX_W-1:0]    last_idx_i,
  input  lltd_pkg::lltd_sts_t sts_i,
  output logic                in_ready_o,
  output lltd_pkg::lltd_cmd_t cmd_o,
  output logic [IDX_W-1:0]    rd_idx_o,
  output logic [IDX_W-1:0]    cmp_idx_o
);
  import lltd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_MARK   = 3'd4;
  localparam logic [2:0] S_WGT    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             cmp_vld_q, cmp_vld_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    scan_idx_d = scan_idx_q;
    cmp_idx_d  = cmp_idx_q;
    cmp_vld_d  = 1'b0;
    cmd_o      = '0;
    cmd_o.load = start_i;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_update) begin
          cmd_o.upd_wr   = 1'b1;
          cmd_o.res_zero = 1'b1;
          state_d        = S_DONE;
        end else if (sts_i.is_idle_req) begin
          cmd_o.rd_en       = 1'b1;
          cmd_o.rd_sel_item = 1'b1;
          state_d           = S_MARK;
        end else begin
          scan_idx_d = '0;
          state_d    = S_SCAN;
        end
      end
      // read slot scan_idx, compare the slot read on the cycle before
      S_SCAN: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.cmp_en    = cmp_vld_q;
        cmd_o.cmp_first = (cmp_idx_q == '0);
        cmp_vld_d       = 1'b1;
        cmp_idx_d       = scan_idx_q;
        if (scan_idx_q == last_idx_i) begin
          state_d = S_DRAIN;
        end else begin
          scan_idx_d = scan_idx_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        cmd_o.cmp_en    = 1'b1;
        cmd_o.cmp_first = (cmp_idx_q == '0);
        state_d         = S_WGT;
      end
      S_MARK: begin
        cmd_o.mark_wr = 1'b1;
        state_d       = S_WGT;
      end
      S_WGT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_idx_q <= '0;
      cmp_idx_q  <= '0;
      cmp_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      cmp_idx_q  <= cmp_idx_d;
      cmp_vld_q  <= cmp_vld_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign rd_idx_o   = scan_idx_q;
  assign cmp_idx_o  = cmp_idx_q;

  // Checks
  `LLTD_ASSERT_IMP(a_scan_in_range, state_q == S_SCAN, scan_idx_q <= last_idx_i,
                   "scan index past last slot")
  `LLTD_ASSERT_NXT(a_accept_decodes, start_i, state_q == S_DECODE,
                   "accepted beat did not reach decode")
  `LLTD_ASSERT_IMP(a_drain_pending, state_q == S_DRAIN, cmp_vld_q,
                   "drain without a pending compare")

endmodule

### rtl/lltd_dpath.sv
// Datapath: counter memories, load compare, weight update and result register.
`timescale 1ns / 1ps
module lltd_dpath #(
  parameter int unsigned MAX_WORKERS = lltd_pkg::DEF_MAX_WORKERS,
  parameter int unsigned COUNT_WIDTH = lltd_pkg::DEF_COUNT_WIDTH,
  localparam int unsigned IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lltd_pkg::lltd_cmd_t cmd_i,
  input  logic [IDX_W-1:0]    rd_idx_i,
  input  logic [IDX_W-1:0]    cmp_idx_i,
  output lltd_pkg::lltd_sts_t sts_o,
  input  logic [1:0]          kind_i,
  input  logic [3:0]          worker_id_i,
  input  logic [15:0]         done_count_i,
  input  logic [1:0]          phase_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                dispatched_o,
  output logic [3:0]          chosen_worker_o,
  output logic [3:0]          task_weight_o
);
  import lltd_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;

  // Latched item
  logic [1:0]  kind_q;
  logic [3:0]  wid_q;
  logic [15:0] done_q;
  logic [1:0]  phase_q;
  logic        wid_ok;
  logic [IDX_W-1:0] wid_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      wid_q   <= worker_id_i;
      done_q  <= done_count_i;
      phase_q <= phase_i;
    end
  end

  assign wid_ok  = (32'(wid_q) < 32'(MAX_WORKERS));
  assign wid_idx = IDX_W'(wid_q);

  assign sts_o.is_update   = kind_q[1];
  assign sts_o.is_idle_req = (kind_q == KIND_IDLE) && wid_ok;

  // Counter memories with one valid bit per entry
  logic [CW-1:0] given_mem [MAX_WORKERS];
  logic [CW-1:0] rep_mem   [MAX_WORKERS];
  logic [CW-1:0] idle_mem  [MAX_WORKERS];
  logic [MAX_WORKERS-1:0] given_vld_q, rep_vld_q, idle_vld_q;

  logic [IDX_W-1:0] rd_addr;
  logic [CW-1:0]    given_rd_q, rep_rd_q, idle_rd_q;
  logic             given_rv_q, rep_rv_q, idle_rv_q;
  logic             upd_we;
  logic [CW-1:0]    given_inc;

  // Best candidate so far
  logic [CW-1:0]    best_q, given_best_q;
  logic [IDX_W-1:0] chosen_q;

  assign rd_addr = cmd_i.rd_sel_item ? wid_idx : rd_idx_i;
  assign upd_we  = cmd_i.upd_wr && (kind_q == KIND_UPDATE) && wid_ok;
  assign given_inc = (given_best_q == {CW{1'b1}}) ? given_best_q : given_best_q + CW'(1);

  // Registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      given_rd_q <= given_mem[rd_addr];
      rep_rd_q   <= rep_mem[rd_addr];
      idle_rd_q  <= idle_mem[rd_addr];
      given_rv_q <= given_vld_q[rd_addr];
      rep_rv_q   <= rep_vld_q[rd_addr];
      idle_rv_q  <= idle_vld_q[rd_addr];
    end
  end

  // Writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      given_mem[chosen_q] <= given_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_we) begin
      rep_mem[wid_idx] <= CW'(done_q);
    end
  end

  logic [CW-1:0] given_e, rep_e, idle_e, base, outst;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_wr) begin
      idle_mem[wid_idx] <= given_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      given_vld_q <= '0;
      rep_vld_q   <= '0;
      idle_vld_q  <= '0;
    end else begin
      if (cmd_i.commit) begin
        given_vld_q[chosen_q] <= 1'b1;
      end
      if (upd_we) begin
        rep_vld_q[wid_idx] <= 1'b1;
      end
      if (cmd_i.mark_wr) begin
        idle_vld_q[wid_idx] <= 1'b1;
      end
    end
  end

  // Outstanding work of the slot just read
  assign given_e = given_rv_q ? given_rd_q : '0;
  assign rep_e   = rep_rv_q ? rep_rd_q : '0;
  assign idle_e  = idle_rv_q ? idle_rd_q : '0;
  assign base    = (rep_e > idle_e) ? rep_e : idle_e;
  assign outst   = (base >= given_e) ? '0 : given_e - base;

  // Least-load tracking; an idle request leaves zero outstanding
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_wr) begin
      best_q       <= '0;
      given_best_q <= given_e;
      chosen_q     <= wid_idx;
    end else if (cmd_i.cmp_en && (cmd_i.cmp_first || (outst < best_q))) begin
      best_q       <= outst;
      given_best_q <= given_e;
      chosen_q     <= cmp_idx_i;
    end
  end

  // Current weight and staged result
  logic [3:0] cur_weight_q;
  logic       res_disp_q;
  logic [3:0] res_chosen_q, res_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_weight_q <= WEIGHT_RST;
    end else if (cmd_i.commit) begin
      cur_weight_q <= weight_of(XW'(best_q) + XW'(1), phase_q == PHASE_FINAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_disp_q   <= 1'b1;
      res_chosen_q <= 4'(chosen_q);
      res_weight_q <= cur_weight_q;
    end else if (cmd_i.res_zero) begin
      res_disp_q   <= 1'b0;
      res_chosen_q <= '0;
      res_weight_q <= '0;
    end
  end

  // Output register
  logic       out_valid_q;
  logic       out_disp_q;
  logic [3:0] out_chosen_q, out_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_disp_q   <= res_disp_q;
      out_chosen_q <= res_chosen_q;
      out_weight_q <= res_weight_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign dispatched_o    = out_disp_q;
  assign chosen_worker_o = out_chosen_q;
  assign task_weight_o   = out_weight_q;

endmodule

### rtl/least_loaded_task_dispatcher.sv
// Sequence: least-load dispatch runs decode, a scan of the n slots in use, drain, weight
// commit and done; idle requests run decode, mark, weight commit and done; updates run
// decode and done. Throughput: one item at a time, set by the one-slot-per-cycle scan over
// the counter memories; the next beat is taken once the result is in the output register,
// and done waits while it is full. A new beat is taken while the previous result waits.
// Reset: asynchronous, active low; clears all counters (per-entry valid bits), the weight
// to 1 and the worker count to 16. No clearing pass is needed.
`timescale 1ns / 1ps
module least_loaded_task_dispatcher #(
  parameter int unsigned MAX_WORKERS = lltd_pkg::DEF_MAX_WORKERS,
  parameter int unsigned COUNT_WIDTH = lltd_pkg::DEF_COUNT_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lltd_req_if.sink    req_i,
  lltd_res_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lltd_pkg::*;

  localparam int unsigned IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

  // Worker count register
  logic [4:0]       num_q;
  logic [4:0]       num_m1;
  logic [IDX_W-1:0] last_idx;
  logic             cfg_we;

  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_NUM_WORKERS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= NUM_WORKERS_RST;
    end else if (cfg_we) begin
      num_q <= pwdata[4:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NUM_WORKERS) ? 32'(num_q) : '0;

  // Last slot of the scan, count clamped to 1..MAX_WORKERS
  assign num_m1 = num_q - 5'd1;
  always_comb begin
    if (num_q == 5'd0) begin
      last_idx = '0;
    end else if (32'(num_q) > 32'(MAX_WORKERS)) begin
      last_idx = IDX_W'(MAX_WORKERS - 1);
    end else begin
      last_idx = IDX_W'(num_m1);
    end
  end

  lltd_cmd_t        cmd;
  lltd_sts_t        sts;
  logic [IDX_W-1:0] rd_idx, cmp_idx;
  logic             in_ready;
  logic             start;

  assign req_i.ready = in_ready;
  assign start       = req_i.valid && in_ready;

  lltd_ctrl #(
    .MAX_WORKERS(MAX_WORKERS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .last_idx_i (last_idx),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .rd_idx_o   (rd_idx),
    .cmp_idx_o  (cmp_idx)
  );

  lltd_dpath #(
    .MAX_WORKERS(MAX_WORKERS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .rd_idx_i        (rd_idx),
    .cmp_idx_i       (cmp_idx),
    .sts_o           (sts),
    .kind_i          (req_i.kind),
    .worker_id_i     (req_i.worker_id),
    .done_count_i    (req_i.done_count),
    .phase_i         (req_i.phase),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .dispatched_o    (rsp_o.dispatched),
    .chosen_worker_o (rsp_o.chosen_worker),
    .task_weight_o   (rsp_o.task_weight)
  );

endmodule

### dv/least_loaded_task_dispatcher_test.sv
// Self-checking testbench for the least-loaded task dispatcher: scoreboard, directed and random traffic.
`timescale 1ns / 1ps
module least_loaded_task_dispatcher_test;
  import lltd_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned SEG_ITEMS   = 150;
  localparam int unsigned CLIMB_ITEMS = 226;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned ROWS        = 18;

  // Codes the package leaves unnamed
  localparam logic [1:0]  KIND_SPARE    = 2'd3;
  localparam logic [1:0]  PHASE_INITIAL = 2'd0;
  localparam logic [1:0]  PHASE_MIDDLE  = 2'd1;
  localparam logic [1:0]  PHASE_SPARE   = 2'd3;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [2:0]  NUM_WORKERS_ADDR = {REG_NUM_WORKERS, 2'b00};

  // ceil(e^k), k = 1..9: weight is one plus the number of these not above backlog+1
  localparam logic [16:0] LN_STEPS [9] = '{
    17'd3, 17'd8, 17'd21, 17'd55, 17'd149, 17'd404, 17'd1097, 17'd2981, 17'd8104
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  worker_id;
    logic [15:0] done_count;
    logic [1:0]  phase;
  } task_req_t;

  typedef struct packed {
    logic       dispatched;
    logic [3:0] chosen_worker;
    logic [3:0] task_weight;
  } task_grant_t;

  typedef struct packed {
    task_req_t   req;
    logic        pinned;
    task_grant_t grant;
  } directed_row_t;

  // Directed rows; pinned rows carry a grant read straight off the spec
  localparam directed_row_t DIRECTED_ROWS [ROWS] = '{
    {KIND_LEAST,  4'd0,  16'h0000, PHASE_INITIAL, 1'b1, 1'b1, 4'd0,  4'd1},
    {KIND_LEAST,  4'd9,  16'h0000, PHASE_MIDDLE,  1'b1, 1'b1, 4'd1,  4'd1},
    {KIND_UPDATE, 4'd0,  16'hFFFF, PHASE_INITIAL, 1'b1, 1'b0, 4'd0,  4'd0},
    {KIND_SPARE,  4'd5,  16'h1234, PHASE_SPARE,   1'b1, 1'b0, 4'd0,  4'd0},
    {KIND_IDLE,   4'd15, 16'h0000, PHASE_SPARE,   1'b1, 1'b1, 4'd15, 4'd1},
    {KIND_LEAST,  4'd0,  16'h0000, PHASE_SPARE,   1'b0, 9'h000},
    {KIND_UPDATE, 4'd0,  16'h0000, PHASE_MIDDLE,  1'b1, 1'b0, 4'd0,  4'd0},
    {KIND_UPDATE, 4'd15, 16'hFFFF, PHASE_FINAL,   1'b1, 1'b0, 4'd0,  4'd0},
    {KIND_LEAST,  4'd3,  16'h0000, PHASE_INITIAL, 1'b0, 9'h000},
    {KIND_LEAST,  4'd3,  16'h0000, PHASE_MIDDLE,  1'b0, 9'h000},
    {KIND_LEAST,  4'd3,  16'h0000, PHASE_FINAL,   1'b0, 9'h000},
    {KIND_LEAST,  4'd3,  16'h0000, PHASE_SPARE,   1'b0, 9'h000},
    {KIND_IDLE,   4'd7,  16'h0000, PHASE_FINAL,   1'b0, 9'h000},
    {KIND_IDLE,   4'd0,  16'hFFFF, PHASE_INITIAL, 1'b0, 9'h000},
    {KIND_LEAST,  4'd0,  16'h0000, PHASE_FINAL,   1'b0, 9'h000},
    {KIND_UPDATE, 4'd1,  16'h0001, PHASE_MIDDLE,  1'b1, 1'b0, 4'd0,  4'd0},
    {KIND_LEAST,  4'd0,  16'h0000, PHASE_INITIAL, 1'b0, 9'h000},
    {KIND_SPARE,  4'd15, 16'hFFFF, PHASE_FINAL,   1'b1, 1'b0, 4'd0,  4'd0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lltd_req_if req_if ();
  lltd_res_if rsp_if ();

  least_loaded_task_dispatcher dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Dispatcher shadow state
  logic [15:0] tasks_given [SLOTS];
  logic [15:0] tasks_done  [SLOTS];
  logic [15:0] idle_marks  [SLOTS];
  logic [3:0]  next_weight;
  logic [4:0]  worker_slots;

  task_grant_t pending_results [$];
  int unsigned mismatch_count;
  int unsigned accepted_count;
  int unsigned grants_seen;
  int unsigned settings_count;
  logic [3:0]  top_weight;
  logic        calm;
  int unsigned hold_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  // Work still owed by a worker; negative backlog reads as zero
  function automatic logic [15:0] backlog_of(input int unsigned w);
    logic [15:0] base;
    base = (tasks_done[w] > idle_marks[w]) ? tasks_done[w] : idle_marks[w];
    return (base >= tasks_given[w]) ? 16'd0 : tasks_given[w] - base;
  endfunction

  function automatic logic [3:0] weight_for_backlog(input logic [15:0] b, input logic [1:0] ph);
    logic [16:0] x;
    logic [3:0]  w;
    x = {1'b0, b} + 17'd1;
    w = 4'd1;
    foreach (LN_STEPS[k]) begin
      if (x >= LN_STEPS[k]) begin
        w = w + 4'd1;
      end
    end
    if (ph == PHASE_FINAL && w > FINAL_CAP) begin
      w = FINAL_CAP;
    end
    if (w > WEIGHT_CAP) begin
      w = WEIGHT_CAP;
    end
    return w;
  endfunction

  // Grant produced by one request; advances the shadow state
  function automatic task_grant_t predict_dispatch(input task_req_t rq);
    task_grant_t g;
    int unsigned n;
    int unsigned pick;
    logic [15:0] best;
    logic [15:0] b;
    g = '0;
    pick = 0;
    if (rq.kind == KIND_UPDATE) begin
      tasks_done[rq.worker_id] = rq.done_count;
      return g;
    end
    if (rq.kind == KIND_SPARE) begin
      return g;
    end
    if (rq.kind == KIND_IDLE) begin
      pick = rq.worker_id;
      idle_marks[pick] = tasks_given[pick];
    end else begin
      // Scan the slots in use; strict less-than keeps the lowest index on ties
      n = (worker_slots == 5'd0) ? 1 : (worker_slots > SLOTS) ? SLOTS : worker_slots;
      best = backlog_of(0);
      for (int unsigned i = 1; i < n; i++) begin
        b = backlog_of(i);
        if (b < best) begin
          best = b;
          pick = i;
        end
      end
    end
    g.dispatched    = 1'b1;
    g.chosen_worker = 4'(pick);
    g.task_weight   = next_weight;
    next_weight = weight_for_backlog(backlog_of(pick), rq.phase);
    if (tasks_given[pick] != COUNT_MAX) begin
      tasks_given[pick] = tasks_given[pick] + 16'd1;
    end
    return g;
  endfunction

  // One request beat, with an optional idle burst ahead of it
  task automatic send_request(input task_req_t rq, input logic pinned, input task_grant_t pin);
    task_grant_t want;
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= rq.kind;
    req_if.worker_id  <= rq.worker_id;
    req_if.done_count <= rq.done_count;
    req_if.phase      <= rq.phase;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    want = predict_dispatch(rq);
    pending_results.push_back(pinned ? pin : want);
    accepted_count++;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // APB read of the worker count, compared with the stored value
  task automatic check_worker_slots(input logic [4:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= NUM_WORKERS_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {27'd0, want}) begin
      flag_error($sformatf("num_workers readback: want %0d got %0h", want, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // APB write while idle; upper data bits carry noise
  task automatic set_worker_slots(input logic [4:0] v);
    drain();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NUM_WORKERS_ADDR;
    pwdata  <= {27'($urandom), v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    worker_slots = v;
    settings_count++;
    check_worker_slots(v);
  endtask

  // Result-side backpressure in bursts
  always @(posedge clk_i) begin
    logic ready_next;
    ready_next = 1'b1;
    if (hold_left != 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      hold_left  = $urandom_range(0, 7);
      ready_next = 1'b0;
    end
    rsp_if.ready <= ready_next;
  end

  // Result checker
  always @(posedge clk_i) begin
    task_grant_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected beat: disp=%0d worker=%0d weight=%0d",
                             rsp_if.dispatched, rsp_if.chosen_worker, rsp_if.task_weight));
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.dispatched !== want.dispatched ||
            rsp_if.chosen_worker !== want.chosen_worker ||
            rsp_if.task_weight !== want.task_weight) begin
          flag_error($sformatf("want disp=%0d worker=%0d weight=%0d, got disp=%0d worker=%0d weight=%0d",
                               want.dispatched, want.chosen_worker, want.task_weight,
                               rsp_if.dispatched, rsp_if.chosen_worker, rsp_if.task_weight));
        end
        if (want.dispatched) begin
          grants_seen++;
          if (want.task_weight > top_weight) begin
            top_weight = want.task_weight;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    task_req_t   rq;
    logic [4:0]  v;
    logic [15:0] g;

    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.kind       = KIND_LEAST;
    req_if.worker_id  = 4'd0;
    req_if.done_count = 16'd0;
    req_if.phase      = PHASE_INITIAL;
    rsp_if.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = 3'd0;
    pwdata            = 32'd0;
    calm              = 1'b0;
    hold_left         = 0;
    mismatch_count    = 0;
    accepted_count    = 0;
    grants_seen       = 0;
    settings_count    = 0;
    top_weight        = 4'd0;
    for (int i = 0; i < SLOTS; i++) begin
      tasks_given[i] = 16'd0;
      tasks_done[i]  = 16'd0;
      idle_marks[i]  = 16'd0;
    end
    next_weight  = WEIGHT_RST;
    worker_slots = NUM_WORKERS_RST;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    check_worker_slots(NUM_WORKERS_RST);

    // Directed rows at the reset worker count
    foreach (DIRECTED_ROWS[r]) begin
      send_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].pinned, DIRECTED_ROWS[r].grant);
    end
    req_if.valid <= 1'b0;

    // Random traffic across worker-count settings, zero and out-of-range ones included
    for (int s = 0; s < 7; s++) begin
      case (s)
        0:       v = NUM_WORKERS_RST;
        1:       v = 5'd0;
        2:       v = 5'd1;
        3:       v = 5'd31;
        4:       v = 5'd17;
        5:       v = 5'($urandom_range(2, 15));
        default: v = 5'($urandom_range(0, 31));
      endcase
      set_worker_slots(v);
      for (int unsigned k = 0; k < SEG_ITEMS; k++) begin
        rq.worker_id = 4'($urandom_range(0, 15));
        rq.phase     = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 99)) inside
          [0:39]:  rq.kind = KIND_LEAST;
          [40:64]: rq.kind = KIND_IDLE;
          [65:92]: rq.kind = KIND_UPDATE;
          default: rq.kind = KIND_SPARE;
        endcase
        // Completion reports: zero, the maximum, near what the worker was given, or random
        g = tasks_given[rq.worker_id];
        case ($urandom_range(0, 5))
          0:       rq.done_count = 16'h0000;
          1:       rq.done_count = COUNT_MAX;
          2, 3:    rq.done_count = (g > 16'd3) ? g - 16'($urandom_range(0, 3)) : g;
          default: rq.done_count = 16'($urandom);
        endcase
        send_request(rq, 1'b0, '0);
      end
      req_if.valid <= 1'b0;
    end

    // Single slot, back to back: backlog climbs through the lower weight steps
    calm = 1'b1;
    set_worker_slots(5'd1);
    send_request({KIND_UPDATE, 4'd0, 16'h0000, PHASE_INITIAL}, 1'b0, '0);
    for (int unsigned k = 0; k < CLIMB_ITEMS; k++) begin
      send_request({KIND_LEAST, 4'($urandom), 16'($urandom), 2'($urandom)}, 1'b0, '0);
    end
    send_request({KIND_IDLE, 4'd9, 16'h0000, PHASE_MIDDLE}, 1'b0, '0);
    send_request({KIND_UPDATE, 4'd0, COUNT_MAX, PHASE_INITIAL}, 1'b0, '0);
    send_request({KIND_LEAST, 4'd0, 16'h0000, PHASE_SPARE}, 1'b0, '0);
    send_request({KIND_LEAST, 4'd0, 16'h0000, PHASE_FINAL}, 1'b0, '0);
    req_if.valid <= 1'b0;

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("Run: %0d requests accepted, %0d grants checked, %0d worker-count settings,",
             accepted_count, grants_seen, settings_count);
    $display("     grant weights reached %0d, %0d mismatches.", top_weight, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
